FILE: hdl/swfp_pkg.sv
// Shared types, constants and the CRC-8 helper for the SSIF write framer.
// Used by swfp_seq, swfp_obuf and ssif_write_framer_with_pec_core.
// No dependencies.
package swfp_pkg;

    // Largest accepted payload length is MAX_LEN - 1.
    localparam int MAX_LEN = 32;
    localparam logic [8:0] LEN_LIMIT = 9'(MAX_LEN);

    localparam int LEN_W  = 5;
    localparam int ADDR_W = 7;

    // Item kinds carried in tuser on the input side.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_WR_CMD     = 1'b1;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef struct packed {
        logic             action;
        logic [7:0]       payload_byte;
        logic [5:0]       net_function;
        logic [1:0]       logical_unit;
        logic [7:0]       ipmi_command;
        logic [LEN_W-1:0] payload_length;
    } t_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_pec;
        logic       last;
    } t_beat;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

FILE: hdl/swfp_obuf.sv
// Output register stage for the framer's byte stream.
// Depends on swfp_pkg for the beat type.
module swfp_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  swfp_pkg::t_beat i_beat,
    output logic           o_ready,
    output logic           o_valid,
    output swfp_pkg::t_beat o_beat,
    input  logic           i_ready
);
    import swfp_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: hdl/swfp_seq.sv
// Item register and byte sequencer: turns each item into its frame bytes,
// one per cycle while the output takes them, and keeps the running PEC
// and the message state. Depends on swfp_pkg.
module swfp_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [swfp_pkg::ADDR_W-1:0]  i_slave_addr,
    input  logic [7:0]                   i_wr_cmd,
    input  logic                         i_in_valid,
    input  swfp_pkg::t_item              i_in_item,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output swfp_pkg::t_beat              o_out_beat,
    input  logic                         i_out_ready
);
    import swfp_pkg::*;

    localparam logic [2:0] STEP_0 = 3'd0;
    localparam logic [2:0] STEP_1 = 3'd1;
    localparam logic [2:0] STEP_2 = 3'd2;
    localparam logic [2:0] STEP_3 = 3'd3;
    localparam logic [2:0] STEP_4 = 3'd4;

    logic             r_cur_valid;
    t_item            r_item;
    logic [2:0]       r_step;
    logic [7:0]       r_crc;
    logic [LEN_W-1:0] r_rem;
    logic             r_open;

    logic       is_start;
    logic       reject;
    logic       drop;
    logic       final_step;
    logic       fire;
    logic       done;
    t_beat      beat;
    logic [7:0] crc_base;
    logic [7:0] n_crc;

    always_comb begin
        is_start   = (r_item.action == ACT_START);
        reject     = is_start && ({4'b0, r_item.payload_length} >= LEN_LIMIT);
        drop       = reject || (!is_start && !r_open);
        beat       = '{frame_byte: r_crc, is_pec: 1'b0, last: 1'b0};
        final_step = 1'b0;
        if (is_start) begin
            unique case (r_step)
                STEP_0: beat.frame_byte = i_wr_cmd;
                STEP_1: beat.frame_byte = 8'(r_item.payload_length) + 8'd2;
                STEP_2: beat.frame_byte = {r_item.net_function, r_item.logical_unit};
                STEP_3: begin
                    beat.frame_byte = r_item.ipmi_command;
                    final_step      = (r_item.payload_length != '0);
                end
                STEP_4: begin
                    beat.is_pec = 1'b1;
                    beat.last   = 1'b1;
                    final_step  = 1'b1;
                end
                default: final_step = 1'b1;
            endcase
        end else if (r_step == STEP_0) begin
            beat.frame_byte = r_item.payload_byte;
            final_step      = (r_rem != LEN_W'(1));
        end else begin
            beat.is_pec = 1'b1;
            beat.last   = 1'b1;
            final_step  = 1'b1;
        end

        o_out_valid = r_cur_valid && !drop;
        o_out_beat  = beat;
        fire        = o_out_valid && i_out_ready;
        done        = r_cur_valid && (drop || (fire && final_step));
        o_in_ready  = !r_cur_valid || done;

        // The first header byte restarts the PEC from the write address byte.
        crc_base = (is_start && r_step == STEP_0) ?
                   crc8(CRC_INIT, {i_slave_addr, 1'b0}) : r_crc;
        n_crc    = crc8(crc_base, beat.frame_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= STEP_0;
            r_crc       <= CRC_INIT;
            r_rem       <= '0;
            r_open      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_cur_valid <= i_in_valid;
            end
            if (done) begin
                r_step <= STEP_0;
            end else if (fire) begin
                r_step <= r_step + 3'd1;
            end
            if (fire && !beat.is_pec) begin
                r_crc <= n_crc;
            end
            priority if (fire && beat.is_pec) begin
                r_open <= 1'b0;
                r_rem  <= '0;
            end else if (r_cur_valid && is_start && done) begin
                r_open <= !reject && (r_item.payload_length != '0);
                r_rem  <= reject ? '0 : r_item.payload_length;
            end else if (fire && !is_start) begin
                r_rem <= r_rem - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    // An open message has payload bytes still to come, except while the
    // last payload beat waits for its PEC to leave.
    a_open_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open && !(r_cur_valid && !is_start && r_step != STEP_0)) |-> (r_rem != '0))
        else $error("message open with no bytes remaining");

    // The step counter never runs past the PEC step.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_step <= STEP_4))
        else $error("sequencer step out of range");

    // A dropped or rejected item leaves the item register at once.
    a_drop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_valid && drop) |-> o_in_ready)
        else $error("dropped item held in item register");

    // Sending the PEC closes the message.
    a_pec_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && beat.is_pec) |=> !r_open)
        else $error("message still open after PEC");

    // A payload byte is only ever sent inside an open message.
    a_payload_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !is_start && !beat.is_pec) |-> r_open)
        else $error("payload byte sent outside a message");

endmodule

FILE: hdl/ssif_write_framer_with_pec_core.sv
// Top level of the SSIF single-part write framer with SMBus PEC.
// Depends on swfp_pkg, swfp_seq and swfp_obuf.
//
// The block turns a stream of items into the byte frame of an IPMI SSIF
// single-part write. A start beat (tuser = 0) emits the SMBus command
// code, the payload length plus two, the netfn/lun byte and the IPMI
// command; each payload beat (tuser = 1) emits its data byte. After the
// last payload byte, or right after the header when the length is zero,
// the block emits the PEC with tuser and tlast high. The PEC is CRC-8,
// polynomial 0x07, starting from zero, seeded with the write address byte
// and run over every frame byte. A payload beat outside a message is
// dropped, a new start abandons an open message without a PEC, and a
// start whose length is not below MAX_LEN is dropped and closes any open
// message. Each item sits in one item register while its bytes leave
// through a single byte-wide output register, one byte per cycle while
// the consumer takes them. An item makes one byte for an ordinary payload
// beat, two for the final payload beat, four for a start, five for a start
// with an empty payload, and none for a dropped item. The item register
// takes the next beat in the cycle the current item finishes, even while
// its last byte still waits in the output register for the consumer. The user
// must see that configuration is written only while idle; no logic checks it.
module ssif_write_framer_with_pec_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // Input item stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] payload_byte, [13:8] net_function, [15:14] logical_unit,
    // [23:16] ipmi_command, [28:24] payload_length, [31:29] zero
    input  logic [31:0] i_s_axis_tdata,
    // [0] action
    input  logic        i_s_axis_tuser,
    // Output frame byte stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  o_m_axis_tdata,
    // [0] is_pec
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);
    import swfp_pkg::*;

    logic [ADDR_W-1:0] r_slave_addr;
    logic [7:0]        r_wr_cmd;

    t_item in_item;
    t_beat seq_beat;
    t_beat out_beat;
    logic  seq_valid;
    logic  obuf_ready;

    // Configuration registers; the write command code is the first frame byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= ADDR_W'(16);
            r_wr_cmd     <= 8'd2;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[ADDR_W-1:0];
                CFG_WR_CMD:     r_wr_cmd     <= i_cfg_data;
                default:        r_wr_cmd     <= r_wr_cmd;
            endcase
        end
    end

    assign in_item.action         = i_s_axis_tuser;
    assign in_item.payload_byte   = i_s_axis_tdata[7:0];
    assign in_item.net_function   = i_s_axis_tdata[13:8];
    assign in_item.logical_unit   = i_s_axis_tdata[15:14];
    assign in_item.ipmi_command   = i_s_axis_tdata[23:16];
    assign in_item.payload_length = i_s_axis_tdata[28:24];

    swfp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slave_addr (r_slave_addr),
        .i_wr_cmd     (r_wr_cmd),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_item    (in_item),
        .o_in_ready   (o_s_axis_tready),
        .o_out_valid  (seq_valid),
        .o_out_beat   (seq_beat),
        .i_out_ready  (obuf_ready)
    );

    swfp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seq_valid),
        .i_beat  (seq_beat),
        .o_ready (obuf_ready),
        .o_valid (o_m_axis_tvalid),
        .o_beat  (out_beat),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = out_beat.frame_byte;
    assign o_m_axis_tuser = out_beat.is_pec;
    assign o_m_axis_tlast = out_beat.last;

endmodule

FILE: tb/ssif_frame_checker.sv
// Checker for the SSIF write framer: predicts the SMBus frame bytes of every
// accepted input beat and compares them with the beats on the output stream.
// Depends on swfp_pkg for the register indexes, item kinds and beat layout.
`timescale 1ns / 1ps

module ssif_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    import swfp_pkg::*;

    localparam logic [7:0] PEC_POLY = 8'h07;
    localparam int         MAX_REPORTS = 10;

    logic [6:0] bmc_addr;
    logic [7:0] smbus_wr_cmd;
    logic [7:0] pec_acc;
    logic [4:0] payload_left;
    logic       msg_open;
    t_beat      frame_bytes_due[$];
    int         mismatches;

    // CRC-8 over one byte, most significant bit first.
    function automatic logic [7:0] pec_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        repeat (8) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ PEC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    task automatic push_data(input logic [7:0] b);
        t_beat e;
        pec_acc      = pec_fold(pec_acc, b);
        e.frame_byte = b;
        e.is_pec     = 1'b0;
        e.last       = 1'b0;
        frame_bytes_due.push_back(e);
    endtask

    task automatic push_pec();
        t_beat e;
        e.frame_byte = pec_acc;
        e.is_pec     = 1'b1;
        e.last       = 1'b1;
        frame_bytes_due.push_back(e);
        msg_open     = 1'b0;
        payload_left = '0;
    endtask

    task automatic predict_frame_bytes(input logic act, input logic [31:0] d);
        logic [7:0] pb;
        logic [5:0] nf;
        logic [1:0] lu;
        logic [7:0] cmd;
        logic [4:0] len;
        pb  = d[7:0];
        nf  = d[13:8];
        lu  = d[15:14];
        cmd = d[23:16];
        len = d[28:24];
        if (act == ACT_START) begin
            // A start always closes whatever was open, even when it is refused.
            msg_open     = 1'b0;
            payload_left = '0;
            if (int'(len) < MAX_LEN) begin
                pec_acc = pec_fold(8'h00, {bmc_addr, 1'b0});
                push_data(smbus_wr_cmd);
                push_data({3'b000, len} + 8'd2);
                push_data({nf, lu});
                push_data(cmd);
                if (len == 0) begin
                    push_pec();
                end else begin
                    msg_open     = 1'b1;
                    payload_left = len;
                end
            end
        end else if (msg_open) begin
            push_data(pb);
            payload_left = payload_left - 5'd1;
            if (payload_left == 0) begin
                push_pec();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_beat e;
        if (!i_rst_n) begin
            bmc_addr     = 7'd16;
            smbus_wr_cmd = 8'd2;
            pec_acc      = '0;
            payload_left = '0;
            msg_open     = 1'b0;
            frame_bytes_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_SLAVE_ADDR) begin
                    bmc_addr = i_cfg_data[6:0];
                end else begin
                    smbus_wr_cmd = i_cfg_data;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_frame_bytes(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected frame byte %02h pec %0b last %0b",
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                    end
                end else begin
                    e = frame_bytes_due.pop_front();
                    if (e.frame_byte !== i_m_tdata || e.is_pec !== i_m_tuser ||
                        e.last !== i_m_tlast) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("expected %02h pec %0b last %0b, got %02h pec %0b last %0b",
                                     e.frame_byte, e.is_pec, e.last,
                                     i_m_tdata, i_m_tuser, i_m_tlast);
                        end
                    end
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = frame_bytes_due.size();
    end

endmodule

FILE: tb/ssif_write_framer_with_pec_core_test.sv
// Top of the SSIF write framer testbench: clock, reset, stimulus, verdict.
// Depends on swfp_pkg, ssif_frame_checker and ssif_write_framer_with_pec_core.
`timescale 1ns / 1ps

module ssif_write_framer_with_pec_core_test;
    import swfp_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    // The longest legitimate quiet stretch is the reset plus the settle time
    // between phases, or a run of receiver stalls, all far below this.
    localparam int QUIET_LIMIT  = 2000;
    // A dropped item can still occupy the item register after the last
    // frame byte has left, so the sender waits SETTLE_CYCLES before touching
    // the registers or ending the run.
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 90;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_idx = CFG_SLAVE_ADDR;
    logic [7:0]  i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = ACT_START;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    int fail_count;
    int bytes_pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // Per phase: sender idle rate and receiver stall rate; register values are set below.
    // Phase zero runs on the reset values of the registers.
    int idle_tab[4]  = '{0, 56, 0, 26};
    int stall_tab[4] = '{0, 0, 56, 26};

    ssif_write_framer_with_pec_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    ssif_frame_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tuser   (o_m_axis_tuser),
        .i_m_tlast   (o_m_axis_tlast),
        .o_fail_count(fail_count),
        .o_pending   (bytes_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides afresh every cycle whether it takes a beat.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any accepted beat on either side counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Input word layout, lowest bits first: payload_byte, net_function,
    // logical_unit, ipmi_command, payload_length, then zero fill.
    function automatic logic [31:0] pack_word(input logic [7:0] pb, input logic [5:0] nf,
                                             input logic [1:0] lu, input logic [7:0] cmd,
                                             input logic [4:0] len);
        return {3'b000, len, cmd, lu, nf, pb};
    endfunction

    // Offers one beat and returns in the time step of the edge that takes it.
    // Valid is lowered only when the sender goes idle, so back-to-back beats
    // keep it high without a glitch in the same time step.
    task automatic send_beat(input logic act, input logic [31:0] word);
        if ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Fields that the block ignores for this kind of beat still carry random
    // values, so nothing leaks from them into the frame unnoticed.
    task automatic send_start(input logic [5:0] nf, input logic [1:0] lu,
                              input logic [7:0] cmd, input logic [4:0] len);
        send_beat(ACT_START, pack_word(8'($urandom), nf, lu, cmd, len));
    endtask

    task automatic send_payload(input logic [7:0] pb);
        send_beat(ACT_PAYLOAD, pack_word(pb, 6'($urandom), 2'($urandom), 8'($urandom),
                                         5'($urandom)));
    endtask

    // Stops the sender until every predicted frame byte has left the block,
    // then lets it settle. The checker's count is read on the falling edge so
    // that it is stable.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (bytes_pending != 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [6:0] addr, input logic [7:0] wr_cmd);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_SLAVE_ADDR;
        i_cfg_data  <= {1'b0, addr};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WR_CMD;
        i_cfg_data  <= wr_cmd;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly complete messages with random content. Some are cut short and
    // abandoned by the next start, and a few stray payload beats are mixed in.
    // Most lengths are short; the full range and the longest length turn up
    // now and then.
    task automatic random_traffic(input int target);
        int    r;
        int    k;
        int    cut;
        logic [4:0] len;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_payload(8'($urandom));
            end else begin
                k = $urandom_range(15);
                if (k == 0) begin
                    len = 5'd31;
                end else if (k < 3) begin
                    len = 5'($urandom_range(31));
                end else begin
                    len = 5'($urandom_range(5));
                end
                send_start(6'($urandom), 2'($urandom), 8'($urandom), len);
                cut = (r < 16) ? $urandom_range(int'(len)) : int'(len);
                for (int i = 0; i < cut; i++) begin
                    send_payload(8'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            case (ph)
                0: begin
                    // Directed part, on the reset register values.
                    // A payload beat with no message open is dropped.
                    send_payload(8'hA5);
                    // Empty payloads with all-zero and all-ones header fields.
                    send_start(6'h00, 2'd0, 8'h00, 5'd0);
                    send_start(6'h3F, 2'd3, 8'hFF, 5'd0);
                    // Short message with extreme payload bytes.
                    send_start(6'h06, 2'd0, 8'h01, 5'd2);
                    send_payload(8'h00);
                    send_payload(8'hFF);
                    // A new start abandons an open message without a PEC.
                    send_start(6'h0A, 2'd2, 8'h34, 5'd3);
                    send_payload(8'h12);
                    send_start(6'h2A, 2'd1, 8'h55, 5'd1);
                    send_payload(8'h5A);
                    // A payload beat right after a closed message is dropped.
                    send_start(6'h15, 2'd2, 8'hAA, 5'd1);
                    send_payload(8'h80);
                    send_payload(8'h33);
                    // Longest length opened and abandoned at once. A length
                    // at or above the maximum cannot be expressed in the
                    // five-bit field, so the refusal case never arises.
                    send_start(6'h01, 2'd1, 8'h7F, 5'd31);
                    send_start(6'h20, 2'd3, 8'h80, 5'd0);
                end
                1: write_regs(7'd0, 8'h00);
                2: write_regs(7'd127, 8'hFF);
                default: write_regs(7'($urandom_range(127)), 8'($urandom_range(255)));
            endcase
            random_traffic(ITEMS_PER_PHASE * (ph + 1));
            // The sender waits here for the frame to empty out before the
            // registers change, which also exercises a full pause.
            drain();
        end

        if (fail_count == 0 && bytes_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
